// File: src/frm_pkg.sv
// Package for the fraction reduce / running minimum core.
// Holds shared constants, the queue entry type and the back part's state type; no dependencies.
`default_nettype none
package frm_pkg;
  localparam int unsigned FrmValueWidth = 32;
  localparam int unsigned FrmFieldWidth = 32;

  typedef struct packed {
    logic [FrmFieldWidth-1:0] numer;
    logic [FrmFieldWidth-1:0] denom;
    logic                     start;
  } frm_item_t;

  typedef enum logic [2:0] {
    FrmIdle,
    FrmGcd,
    FrmDivN,
    FrmDivD,
    FrmCmp,
    FrmOut
  } frm_state_e;
endpackage
`default_nettype wire

// File: src/fraction_reduce_running_min_core.sv
// Reduction: Euclid steps over a W-bit bit-serial divider.
// Throughput: one item at a time through the back part; a two-entry queue
// takes new transfers meanwhile.
// Reset: asynchronous active low; clears queue, control and minimum flag.
`default_nettype none
module fraction_reduce_running_min_core import frm_pkg::*; #(
  parameter int unsigned ValueWidth = FrmValueWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // numer_in[31:0], denom_in[63:32]
  input  wire logic        s_axis_tuser,  // start_set
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [127:0]     m_axis_tdata   // reduced_numer, reduced_denom,
                                          // min_numer, min_denom (low up)
);
  frm_item_t in_item, q_item;
  logic q_valid, q_ready;

  // Pack the incoming transfer into a queue entry.
  assign in_item.numer = s_axis_tdata[31:0];
  assign in_item.denom = s_axis_tdata[63:32];
  assign in_item.start = s_axis_tuser;

  frm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  frm_back #(.ValueWidth(ValueWidth)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata)
  );
endmodule
`default_nettype wire

// File: src/frm_front.sv
// Front part: accepts input transfers into a two-entry queue.
// Depends on frm_pkg.
`default_nettype none
module frm_front import frm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire frm_item_t in_item_i,
  output logic           q_valid_o,
  input  wire logic      q_ready_i,
  output frm_item_t      q_item_o
);
  frm_item_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: src/frm_back.sv
// Back part: reduces one fraction (bit-serial remainder and division),
// updates the running minimum, holds the result. Depends on frm_pkg.
`default_nettype none
module frm_back import frm_pkg::*; #(
  parameter int unsigned ValueWidth = FrmValueWidth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  output logic           q_ready_o,
  input  wire frm_item_t q_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [4*FrmFieldWidth-1:0] out_data_o
);
  localparam int unsigned W  = ValueWidth;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned IW = $clog2(W);

  frm_state_e state_q, state_d;
  logic [W-1:0] a_q, b_q, mn_q, md_q, qt_q, rem_q;
  logic [CW-1:0] bit_q;
  logic neg_q, start_q, zden_q, have_q, mode_q;
  logic signed [W-1:0] rn_q, rd_q, bn_q, bd_q;
  logic signed [2*W-1:0] p1_q, p2_q;
  logic [FrmFieldWidth-1:0] o_rn_q, o_rd_q, o_bn_q, o_bd_q;

  logic signed [W-1:0] n_in, d_in;
  logic [W-1:0] n_mag, d_mag, divisor, dividend;
  logic [W:0] trial;
  logic [W-1:0] lim;
  logic signed [W-1:0] sat_n, sat_d;
  logic [IW-1:0] bidx;

  assign n_in  = q_item_i.numer[W-1:0];
  assign d_in  = q_item_i.denom[W-1:0];
  assign n_mag = n_in[W-1] ? W'(-n_in) : W'(n_in);
  assign d_mag = d_in[W-1] ? W'(-d_in) : W'(d_in);
  assign lim   = {1'b1, {(W-1){1'b0}}};
  assign bidx  = IW'(bit_q - CW'(1));

  // Shared restoring divider: one quotient bit per cycle.
  always_comb begin
    unique case (state_q)
      FrmGcd:  begin dividend = a_q;  divisor = b_q; end
      FrmDivN: begin dividend = mn_q; divisor = a_q; end
      default: begin dividend = md_q; divisor = a_q; end
    endcase
    trial = {rem_q, dividend[bidx]} - {1'b0, divisor};
  end

  always_comb begin
    sat_n = (qt_q >= lim) ? (neg_q ? -$signed(lim) : $signed(~lim))
                          : (neg_q ? -$signed(qt_q) : $signed(qt_q));
    sat_d = (qt_q >= lim) ? $signed(~lim) : $signed(qt_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrmIdle: if (q_valid_i) state_d = FrmGcd;
      FrmGcd:  if (zden_q || (b_q == '0)) state_d = zden_q ? FrmCmp : FrmDivN;
      FrmDivN: if (bit_q == '0) state_d = FrmDivD;
      FrmDivD: if (bit_q == '0) state_d = FrmCmp;
      FrmCmp:  if (mode_q) state_d = FrmOut;
      FrmOut:  if (!out_valid_o || out_ready_i) state_d = FrmIdle;
      default: state_d = FrmIdle;
    endcase
  end

  assign q_ready_o = (state_q == FrmIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrmIdle; have_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FrmOut && state_d == FrmIdle) begin
        out_valid_o <= 1'b1;
        have_q <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FrmIdle: begin
        a_q <= n_mag; b_q <= d_mag; mn_q <= n_mag; md_q <= d_mag;
        neg_q <= n_in[W-1] ^ d_in[W-1];
        start_q <= q_item_i.start; zden_q <= (d_in == '0);
        rn_q <= n_in; rd_q <= d_in;
        rem_q <= '0; bit_q <= CW'(W); mode_q <= 1'b0;
      end
      FrmGcd: begin
        if (!zden_q && b_q != '0) begin
          if (bit_q != '0) begin
            rem_q <= trial[W] ? {rem_q[W-2:0], dividend[bidx]} : trial[W-1:0];
            bit_q <= bit_q - CW'(1);
          end else begin
            a_q <= b_q; b_q <= rem_q; rem_q <= '0; bit_q <= CW'(W);
          end
        end else begin
          rem_q <= '0; bit_q <= CW'(W); qt_q <= '0;
        end
      end
      FrmDivN, FrmDivD: begin
        if (bit_q != '0) begin
          rem_q <= trial[W] ? {rem_q[W-2:0], dividend[bidx]} : trial[W-1:0];
          qt_q  <= {qt_q[W-2:0], ~trial[W]};
          bit_q <= bit_q - CW'(1);
        end else begin
          if (state_q == FrmDivN) begin
            rn_q <= (qt_q == '0) ? '0 : sat_n;
          end else begin
            rd_q <= sat_d;
          end
          rem_q <= '0; qt_q <= '0; bit_q <= CW'(W);
        end
      end
      FrmCmp: begin
        if (!mode_q) begin
          p1_q <= rn_q * bd_q;
          p2_q <= bn_q * rd_q;
          mode_q <= 1'b1;
        end else if (!have_q || start_q || p1_q < p2_q) begin
          bn_q <= rn_q; bd_q <= rd_q;
        end
      end
      FrmOut: begin
        if (!out_valid_o || out_ready_i) begin
          o_rn_q <= FrmFieldWidth'(rn_q); o_rd_q <= FrmFieldWidth'(rd_q);
          o_bn_q <= FrmFieldWidth'(bn_q); o_bd_q <= FrmFieldWidth'(bd_q);
        end
      end
      default: ;
    endcase
  end

  assign out_data_o = {o_bd_q, o_bn_q, o_rd_q, o_rn_q};
endmodule
`default_nettype wire

// File: src/frm_checker.sv
// Port-level checker for the core, attached by bind.
// Depends on nothing but the core's ports.
`default_nettype none
module frm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[63])
    else $error("reduced denominator negative");
  a_min_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[127])
    else $error("minimum denominator negative");
endmodule
bind fraction_reduce_running_min_core frm_checker u_chk (.*);
`default_nettype wire

// File: verif/testbench.sv
// Testbench for fraction_reduce_running_min_core: reduces signed fractions by gcd
// and tracks the running minimum per set; checks every output transfer against
// a predictor in the scoreboard class. Depends on frm_pkg and the core RTL.
`default_nettype none
module testbench;
  import frm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor plus queue of expected output words.
  class frac_scoreboard;
    logic signed [31:0] best_n, best_d;
    bit have_best;
    logic [127:0] pending[$];
    int errors;

    function void reset_state();
      best_n = 0;
      best_d = 0;
      have_best = 0;
      pending.delete();
      errors = 0;
    endfunction

    function longint unsigned euclid(longint unsigned a, longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return euclid_ret(a);
    endfunction

    function longint unsigned euclid_ret(longint unsigned g);
      return g;
    endfunction

    // Build a 32-bit value from magnitude and sign, saturating magnitudes that do not fit.
    function logic signed [31:0] from_mag(longint unsigned m, bit neg);
      longint unsigned lim;
      lim = 64'd1 << 31;
      if (neg) return 32'((m >= lim) ? -longint'(lim) : -longint'(m));
      return 32'((m >= lim) ? longint'(lim - 1) : longint'(m));
    endfunction

    // Note one accepted input transfer and push its expected result.
    function void note_fraction(logic signed [31:0] n, logic signed [31:0] d, bit start);
      longint signed ln, ld;
      longint unsigned mn, md, g;
      logic signed [31:0] rn, rd;
      bit neg;
      ln = n;
      ld = d;
      rn = n;
      rd = d;
      if (d != 0) begin
        mn = (ln < 0) ? -ln : ln;
        md = (ld < 0) ? -ld : ld;
        g = euclid(mn, md);
        neg = (ln < 0) != (ld < 0);
        mn = mn / g;
        md = md / g;
        rn = from_mag(mn, neg && mn != 0);
        rd = from_mag(md, 0);
      end
      if (!have_best || start ||
          (longint'(rn) * longint'(best_d) < longint'(best_n) * longint'(rd))) begin
        best_n = rn;
        best_d = rd;
        have_best = 1;
      end
      pending.push_back({best_d, best_n, rd, rn});
    endfunction

    // Compare one output transfer with the oldest expectation.
    function void check_result(logic [127:0] got);
      logic [127:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output %h", got);
        return;
      end
      want = pending.pop_front();
      for (int f = 0; f < 4; f++) begin
        if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
          errors++;
          if (errors <= 10)
            $display("field %0d mismatch: expected %0d got %0d", f,
                     $signed(want[f*32 +: 32]), $signed(got[f*32 +: 32]));
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic s_valid, s_ready, s_user, m_valid, m_ready;
  logic [63:0] s_data;
  logic [127:0] m_data;

  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  bit stim_done;
  frac_scoreboard sb;

  fraction_reduce_running_min_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Random value never equal to the excluded most negative value.
  function automatic logic signed [31:0] rand_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20) - 10;
      1: v = $urandom_range(0, 2000) - 1000;
      2: v = $signed($urandom_range(1, 1000)) * $signed($urandom_range(1, 1000) * 6);
      default: v = $urandom;
    endcase
    if (v == 32'sh8000_0000) v = 32'sh8000_0001;
    return v;
  endfunction

  // Offer one fraction and hold it until the transfer.
  task automatic send_fraction(logic signed [31:0] n, logic signed [31:0] d, bit start);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_valid <= 0;
      @(negedge clk);
    end
    s_valid <= 1;
    s_data <= {d, n};
    s_user <= start;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_fraction(n, d, start);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus the long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) m_ready <= 0;
    else m_ready <= !hold_off && !($urandom_range(1, 100) <= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_result(m_data);
  end

  initial begin
    hold_off = 0;
    wait (stim_done == 0);
    @(posedge rst_n);
    repeat (50) @(negedge clk);
    // Hold off long enough for the input queue to fill and push back.
    hold_off = 1;
    repeat (20000) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    #100ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    stim_done = 0;
    s_valid = 0;
    s_data = 0;
    s_user = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: extremes, zero numerator, zero denominator, signs, new sets.
    send_fraction(6, 4, 0);
    send_fraction(-6, 4, 0);
    send_fraction(6, -4, 0);
    send_fraction(-6, -4, 0);
    send_fraction(0, 5, 0);
    send_fraction(0, -7, 0);
    send_fraction(3, 0, 0);
    send_fraction(-3, 0, 0);
    send_fraction(0, 0, 0);
    send_fraction(32'sh7fff_ffff, 1, 1);
    send_fraction(32'sh8000_0001, 1, 0);
    send_fraction(1, 32'sh7fff_ffff, 0);
    send_fraction(1, 32'sh8000_0001, 0);
    send_fraction(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
    send_fraction(32'sh8000_0001, 32'sh7fff_ffff, 0);
    send_fraction(32'sh7fff_ffff, 32'sh8000_0001, 0);
    send_fraction(1134903170, 1836311903, 1);
    send_fraction(-1836311903, 1134903170, 0);
    send_fraction(32'sh4000_0000, 32'sh2000_0000, 0);
    send_fraction(12, 18, 1);
    send_fraction(5, 0, 0);
    s_valid <= 0;
    // Pause until every expected result has come.
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < 490; i++) begin
        logic signed [31:0] n, d;
        n = rand_value();
        d = ($urandom_range(0, 15) == 0) ? 0 : rand_value();
        send_fraction(n, d, $urandom_range(0, 9) == 0);
      end
    end

    stim_done = 1;
    s_valid <= 0;
    drain();
    repeat (2000) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
src/frm_pkg.sv
src/frm_front.sv
src/frm_back.sv
src/fraction_reduce_running_min_core.sv
src/frm_checker.sv
verif/testbench.sv
